// ===== hdl/vpfr_pkg.sv =====
// shared types and constants of the reduced-precision float rounder
package vpfr_pkg;

    typedef enum logic [1:0] {
        PATH_NORMAL  = 2'd0,
        PATH_SUBNORM = 2'd1,
        PATH_UNDER   = 2'd2,
        PATH_PASS    = 2'd3
    } t_path;

    typedef enum logic [1:0] {
        CFG_FORMAT    = 2'd0,
        CFG_PRECISION = 2'd1,
        CFG_EMIN      = 2'd2
    } t_cfg_idx;

    localparam logic [63:0] MASK32 = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] MASK64 = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam int NGRP = 7;

    localparam logic signed [13:0] BIAS64 = 14'sd1023;
    localparam logic signed [13:0] BIAS32 = 14'sd127;
    localparam logic signed [13:0] MAN64  = 14'sd52;
    localparam logic signed [13:0] MAN32  = 14'sd23;

endpackage

// ===== hdl/variable_precision_float_rounder.sv =====
// top level of the reduced-precision float rounder
//
// usage:
//   item in: pulse i_start with i_operand_bits; o_busy is always low, so an
//   item is taken on every cycle that i_start is high.
//   item out: o_done is high for one cycle with o_result_bits and
//   o_path_taken, once the item has passed the input register, the
//   leading-one register after the per-byte search and the result register.
//   throughput: one item per cycle.
//   config: i_cfg_we writes i_cfg_wdata to register i_cfg_index at once
//   (0 format, 1 precision, 2 emin); write only while no item is in flight.
//   reset: i_rst_n low clears the pipeline valid flags and loads binary64,
//   precision 52, emin -1022.
//   the receiver cannot hold results off; every result appears exactly once.
module variable_precision_float_rounder
    import vpfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_wdata,
    input  logic [63:0] i_operand_bits,
    output logic        o_done,
    output logic [63:0] o_result_bits,
    output logic [1:0]  o_path_taken
);

    logic               r_fmt;
    logic [5:0]         r_prec;
    logic [10:0]        r_emin;

    logic               r_v1;
    logic [63:0]        r_x1;
    logic               r_v2;
    logic [63:0]        r_x2;
    logic [NGRP-1:0]    r_nz;
    logic [2:0]         r_pos [NGRP];
    logic               r_v3;
    logic [63:0]        r_res;
    t_path              r_path;

    logic [55:0]        s1_frac;
    logic [NGRP-1:0]    n_nz;
    logic [2:0]         n_pos [NGRP];

    logic [63:0]        n_res;
    t_path              n_path;

    assign o_busy = 1'b0;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt  <= 1'b1;
            r_prec <= 6'd52;
            r_emin <= 11'h402;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FORMAT:    r_fmt  <= i_cfg_wdata[0];
                CFG_PRECISION: r_prec <= i_cfg_wdata[5:0];
                CFG_EMIN:      r_emin <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // stage 1: per-byte leading one search of the fraction
    always_comb begin
        s1_frac = r_fmt ? {4'b0, r_x1[51:0]} : {33'b0, r_x1[22:0]};
        for (int g = 0; g < NGRP; g++) begin
            n_nz[g]  = |s1_frac[8*g +: 8];
            n_pos[g] = 3'd0;
            for (int b = 0; b < 8; b++) begin
                if (s1_frac[8*g + b]) n_pos[g] = 3'(b);
            end
        end
    end

    // stage 2: exponent, path and rounding
    logic [63:0]        x;
    logic               sgn;
    logic [10:0]        expf;
    logic [10:0]        emax;
    logic signed [13:0] bias, manw, e, ee, q, s, sh, emin, p, qb;
    logic [5:0]         top;
    logic [63:0]        mag, mask, rem, half, sbit, rnd;
    logic               is_pass, is_zero, path0, under, lsb, up;
    logic [10:0]        expv;

    always_comb begin
        x     = r_x2;
        bias  = r_fmt ? BIAS64 : BIAS32;
        manw  = r_fmt ? MAN64 : MAN32;
        sgn   = r_fmt ? x[63] : x[31];
        expf  = r_fmt ? x[62:52] : {3'b0, x[30:23]};
        emax  = r_fmt ? 11'h7FF : 11'h0FF;
        mag   = r_fmt ? {1'b0, x[62:0]} : {33'b0, x[30:0]};
        emin  = {{3{r_emin[10]}}, r_emin};
        p     = {8'b0, r_prec};
        top   = 6'd0;
        for (int g = 0; g < NGRP; g++) begin
            if (r_nz[g]) top = 6'(8*g) + {3'b0, r_pos[g]};
        end
        is_pass = (expf == emax) || (p >= manw);
        is_zero = (expf == 11'd0) && !(|r_nz);
        if (expf != 11'd0) begin
            e  = $signed({3'b0, expf}) - bias;
            ee = e - manw;
        end else begin
            ee = 14'sd1 - bias - manw;
            e  = ee + $signed({8'b0, top});
        end
        path0 = (e >= emin);
        q     = path0 ? (e - p) : (emin - p);
        under = !path0 && (e < q);
        s     = q - ee;

        mask = (64'd1 << s[5:0]) - 64'd1;
        rem  = mag & mask;
        half = 64'd1 << (s[5:0] - 6'd1);
        sbit = 64'd1 << s[5:0];
        lsb  = ((s == manw) && (expf != 11'd0)) ? 1'b1 : |(mag & sbit);
        up   = (rem > half) || ((rem == half) && lsb);
        rnd  = (mag & ~mask) + (up ? sbit : 64'd0);

        // underflow: zero or the smallest virtual subnormal
        qb   = q + bias;
        expv = qb[10:0];
        sh   = q - (14'sd1 - bias - manw);

        n_res  = x;
        n_path = PATH_PASS;
        if (is_pass) begin
            n_res  = x;
            n_path = PATH_PASS;
        end else if (is_zero) begin
            n_res  = r_fmt ? {sgn, 63'b0} : {32'b0, sgn, 31'b0};
            n_path = PATH_UNDER;
        end else if (under) begin
            n_path = PATH_UNDER;
            if (e != q - 14'sd1) begin
                rnd = 64'd0;
            end else if (q > bias) begin
                rnd = r_fmt ? {1'b0, emax, 52'b0} : {33'b0, emax[7:0], 23'b0};
            end else if (q >= 14'sd1 - bias) begin
                rnd = r_fmt ? {1'b0, expv, 52'b0} : {33'b0, expv[7:0], 23'b0};
            end else if (sh >= 14'sd0) begin
                rnd = 64'd1 << sh[5:0];
            end else begin
                rnd = 64'd0;
            end
            n_res = r_fmt ? {sgn, rnd[62:0]} : {32'b0, sgn, rnd[30:0]};
        end else begin
            n_path = path0 ? PATH_NORMAL : PATH_SUBNORM;
            if (s <= 14'sd0) n_res = x;
            else n_res = r_fmt ? {sgn, rnd[62:0]} : {32'b0, sgn, rnd[30:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x1   <= i_operand_bits & (r_fmt ? MASK64 : MASK32);
        r_x2   <= r_x1;
        r_nz   <= n_nz;
        r_pos  <= n_pos;
        r_res  <= n_res;
        r_path <= n_path;
    end

    assign o_done        = r_v3;
    assign o_result_bits = r_res;
    assign o_path_taken  = r_path;

    a_b32_high_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !r_fmt) |-> (o_result_bits[63:32] == 32'd0))
        else $error("binary32 result has upper bits set");

    a_under_pow2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_path_taken == PATH_UNDER) |->
        (r_fmt ? ($countones(o_result_bits[51:0]) <= 1)
               : ($countones(o_result_bits[22:0]) <= 1)))
        else $error("underflow result is not zero or a power of two");

    a_sign_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_fmt) |-> (o_result_bits[63] == $past(r_x1[63], 2)))
        else $error("sign bit changed");

    a_b32_sign_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !r_fmt) |-> (o_result_bits[31] == $past(r_x1[31], 2)))
        else $error("binary32 sign bit changed");

endmodule

// ===== verif/tb_variable_precision_float_rounder.sv =====
// testbench for the reduced-precision float rounder: predicted results checked per item
`timescale 1ns / 100ps

class rounding_scoreboard;
    logic [63:0] exp_bits[$];
    logic [1:0]  exp_path[$];
    int          mismatches;

    function void note_item(logic [63:0] bits, logic [1:0] path);
        exp_bits.push_back(bits);
        exp_path.push_back(path);
    endfunction

    function void check_result(logic [63:0] bits, logic [1:0] path);
        logic [63:0] eb;
        logic [1:0]  ep;
        if (exp_bits.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result %h path %0d", bits, path);
            return;
        end
        eb = exp_bits.pop_front();
        ep = exp_path.pop_front();
        if (eb !== bits || ep !== path) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected %h path %0d, got %h path %0d",
                         eb, ep, bits, path);
        end
    endfunction

    function int pending();
        return exp_bits.size();
    endfunction
endclass

module tb_variable_precision_float_rounder;
    import vpfr_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_start = 0;
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_index = CFG_FORMAT;
    logic [10:0] i_cfg_wdata = 0;
    logic [63:0] i_operand_bits = 0;
    logic        o_busy, o_done;
    logic [63:0] o_result_bits;
    logic [1:0]  o_path_taken;

    rounding_scoreboard board = new();
    bit          fmt64;
    int          prec;
    int          emin;
    int          cycles;
    bit          calm;
    int          item_count;

    variable_precision_float_rounder dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 200000) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_done)
            board.check_result(o_result_bits, o_path_taken);

    function automatic int msb_of(logic [63:0] v);
        int h;
        h = -1;
        for (int i = 0; i < 64; i++)
            if (v[i]) h = i;
        return h;
    endfunction

    function automatic logic [63:0] encode_value(int man, int bias, int ew,
            logic [63:0] sgn, logic [63:0] q, int qexp);
        int h, ev, sh;
        logic [63:0] frac, fmask;
        fmask = (64'd1 << man) - 1;
        if (q == 0) return sgn;
        h = msb_of(q);
        ev = qexp + h;
        if (ev > bias) return sgn | (((64'd1 << ew) - 1) << man);
        if (ev >= 1 - bias) begin
            frac = (h <= man) ? (q << (man - h)) : (q >> (h - man));
            return sgn | (64'(ev + bias) << man) | (frac & fmask);
        end
        sh = qexp - (1 - bias - man);
        if (sh >= 0) frac = (sh < 64) ? (q << sh) : 0;
        else frac = (-sh < 64) ? (q >> (-sh)) : 0;
        return sgn | (frac & fmask);
    endfunction

    function automatic void round_operand(logic [63:0] xin, output logic [63:0] res,
                                          output logic [1:0] path);
        int man, ew, bias, e, ee, qq, s;
        logic [63:0] x, sgn, expf, frac, sig, emax, q, rem, half;
        man = fmt64 ? 52 : 23;
        ew = fmt64 ? 11 : 8;
        bias = fmt64 ? 1023 : 127;
        x = fmt64 ? xin : (xin & MASK32);
        emax = (64'd1 << ew) - 1;
        sgn = x & (64'd1 << (man + ew));
        expf = (x >> man) & emax;
        frac = x & ((64'd1 << man) - 1);
        if (expf == emax || prec >= man) begin
            res = x; path = PATH_PASS; return;
        end
        if (expf == 0) begin
            sig = frac; ee = 1 - bias - man;
        end else begin
            sig = frac | (64'd1 << man); ee = int'(expf) - bias - man;
        end
        if (sig == 0) begin
            res = sgn; path = PATH_UNDER; return;
        end
        e = ee + msb_of(sig);
        if (e >= emin) begin
            qq = e - prec; path = PATH_NORMAL;
        end else begin
            qq = emin - prec; path = PATH_SUBNORM;
            if (e < qq) begin
                res = encode_value(man, bias, ew, sgn, (e >= qq - 1) ? 1 : 0, qq);
                path = PATH_UNDER;
                return;
            end
        end
        s = qq - ee;
        if (s <= 0) res = x;
        else if (s >= 64) res = encode_value(man, bias, ew, sgn, 0, qq);
        else begin
            q = sig >> s;
            rem = sig & ((64'd1 << s) - 1);
            half = 64'd1 << (s - 1);
            if (rem > half || (rem == half && q[0])) q++;
            res = encode_value(man, bias, ew, sgn, q, qq);
        end
    endfunction

    task automatic write_reg(t_cfg_idx idx, int value);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value[10:0];
        @(posedge i_clk);
        case (idx)
            CFG_FORMAT:    fmt64 = value[0];
            CFG_PRECISION: prec = value[5:0];
            default:       emin = $signed(value[10:0]);
        endcase
    endtask

    task automatic drain();
        i_start <= 0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_item(logic [63:0] x);
        logic [63:0] r;
        logic [1:0]  p;
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_start <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_start <= 1;
        i_operand_bits <= x;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        round_operand(x, r, p);
        board.note_item(r, p);
        item_count++;
    endtask

    function automatic logic [63:0] random_operand();
        logic [63:0] x;
        int expf, ebias;
        x = {$urandom, $urandom};
        ebias = fmt64 ? 1023 : 127;
        case ($urandom_range(0, 5))
            0: expf = ebias + emin + $urandom_range(0, 8) - 4;
            1: expf = ebias + emin - prec + $urandom_range(0, 6) - 3;
            2: expf = $urandom_range(0, 3);
            3: expf = fmt64 ? $urandom_range(2040, 2047) : $urandom_range(250, 255);
            default: expf = -1;
        endcase
        if (expf >= 0) begin
            if (fmt64) x[62:52] = expf[10:0];
            else x[30:23] = expf[7:0];
        end
        if ($urandom_range(0, 4) == 0) begin
            if (fmt64) x[51:0] = x[51:0] & ~((52'd1 << $urandom_range(0, 52)) - 1);
            else x[22:0] = x[22:0] & ~((23'd1 << $urandom_range(0, 23)) - 1);
        end
        return x;
    endfunction

    task automatic set_phase(bit f, int p, int em);
        drain();
        write_reg(CFG_FORMAT, f);
        write_reg(CFG_PRECISION, p);
        write_reg(CFG_EMIN, em);
        i_cfg_we <= 0;
    endtask

    initial begin
        fmt64 = 1; prec = 52; emin = -1022;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: defaults pass through, then extremes
        send_item(64'h0);
        send_item(64'hFFFF_FFFF_FFFF_FFFF);
        set_phase(1, 10, -1022);
        send_item(64'h8000_0000_0000_0000);
        send_item(64'h7FF0_0000_0000_0000);
        send_item(64'h7FF8_0000_0000_0001);
        send_item(64'h7FEF_FFFF_FFFF_FFFF);
        send_item(64'h3FF0_0200_0000_0000);
        send_item(64'h3FF0_0600_0000_0000);
        send_item(64'h0000_0000_0000_0001);
        send_item(64'h8000_0000_0000_0001);
        set_phase(0, 0, 0);
        send_item(64'hFFFF_FFFF_3F80_0000);
        send_item(64'h3FC0_0000);
        send_item(64'h3F00_0000);
        send_item(64'hBE80_0000);
        send_item(64'hBE7F_FFFF);
        send_item(64'h7F7F_FFFF);
        send_item(64'h7F80_0000);
        set_phase(0, 5, -1022);
        send_item(64'h0000_0001);
        send_item(64'h8040_0000);
        send_item(64'h3F81_0000);
        set_phase(1, 63, -1);
        send_item(64'h3FF1_2345_6789_ABCD);

        for (int ph = 0; ph < 14; ph++) begin
            case (ph)
                0: set_phase(1, 0, -1022);
                1: set_phase(1, 52, 0);
                2: set_phase(1, 51, -1022);
                3: set_phase(0, 22, -126);
                4: set_phase(0, 23, -10);
                5: set_phase(0, 0, -1022);
                default: set_phase($urandom_range(0, 1), $urandom_range(0, 63),
                                   -int'($urandom_range(0, 1022)));
            endcase
            calm = (ph >= 12);
            for (int n = 0; n < 80; n++) send_item(random_operand());
        end
        drain();
        $display("covered %0d items over both formats, precisions 0 to 63,", item_count);
        $display("emin -1022 to 0: normal, subnormal, underflow and pass-through paths");
        if (board.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/vpfr_pkg.sv
hdl/variable_precision_float_rounder.sv
verif/tb_variable_precision_float_rounder.sv
